FILE: rtl/ox_pkg.sv
// Shared types and constants for the order crossover block.
`default_nettype none

package ox_pkg;

  localparam int CITY_W     = 6;
  localparam int POS_W      = 6;
  localparam int COUNT_W    = 7;
  localparam int CITY_SPACE = 64;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd51;
  localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd2;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [POS_W-1:0]  position;
    logic [CITY_W-1:0] city;
    logic [POS_W-1:0]  cut_first;
    logic [POS_W-1:0]  cut_second;
    logic              swap_parents;
  } ox_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  child_position;
    logic [CITY_W-1:0] child_city;
    logic              last;
  } ox_out_t;

  typedef enum logic [1:0] {
    KIND_LOAD_A,
    KIND_LOAD_B,
    KIND_RUN
  } ox_kind_t;

  typedef struct packed {
    ox_kind_t           kind;
    logic [POS_W-1:0]   position;
    logic [CITY_W-1:0]  city;
    logic [POS_W-1:0]   lo;
    logic [POS_W-1:0]   hi;
    logic [COUNT_W-1:0] n;
    logic               swap;
  } ox_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ox_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_FILL,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_WR
  } ox_state_t;

endpackage

`default_nettype wire

FILE: rtl/ox_front.sv
// Front end: holds the city count, decodes commands and prepares jobs.
`default_nettype none

module ox_front #(
  parameter int MAX_CITIES = 64
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  ox_pkg::ox_in_t              in_data,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire [ox_pkg::COUNT_W-1:0]   cfg_data,
  input  ox_pkg::ox_qstat_t           qstat,
  output logic                        push,
  output ox_pkg::ox_job_t             job
);
  import ox_pkg::*;

  localparam logic [COUNT_W-1:0] N_MAX = COUNT_W'(MAX_CITIES);

  logic [COUNT_W-1:0] city_count_r;
  logic [COUNT_W-1:0] n_act;
  logic [COUNT_W-1:0] n_top;
  logic [POS_W-1:0]   cut_lo;
  logic [POS_W-1:0]   cut_hi;
  logic               pos_ok;
  logic               keep;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= COUNT_RESET;
    end else if (cfg_valid) begin
      city_count_r <= cfg_data;
    end
  end

  always_comb begin
    if (city_count_r < COUNT_MIN) begin
      n_act = COUNT_MIN;
    end else if (city_count_r > N_MAX) begin
      n_act = N_MAX;
    end else begin
      n_act = city_count_r;
    end
    n_top = n_act - COUNT_W'(1);
  end

  // sort the cuts, then saturate both to the last position
  always_comb begin
    if (in_data.cut_first < in_data.cut_second) begin
      cut_lo = in_data.cut_first;
      cut_hi = in_data.cut_second;
    end else begin
      cut_lo = in_data.cut_second;
      cut_hi = in_data.cut_first;
    end
    if ({1'b0, cut_lo} > n_top) cut_lo = n_top[POS_W-1:0];
    if ({1'b0, cut_hi} > n_top) cut_hi = n_top[POS_W-1:0];
  end

  assign pos_ok = {1'b0, in_data.position} < N_MAX;

  always_comb begin
    job.position = in_data.position;
    job.city     = in_data.city;
    job.lo       = cut_lo;
    job.hi       = cut_hi;
    job.n        = n_act;
    job.swap     = in_data.swap_parents;
    unique case (in_data.command)
      CMD_LOAD_A: begin
        job.kind = KIND_LOAD_A;
        keep     = pos_ok;
      end
      CMD_LOAD_B: begin
        job.kind = KIND_LOAD_B;
        keep     = pos_ok;
      end
      CMD_RUN: begin
        job.kind = KIND_RUN;
        keep     = 1'b1;
      end
      default: begin
        job.kind = KIND_RUN;
        keep     = 1'b0;
      end
    endcase
  end

  // unused commands and out-of-range loads are taken and dropped
  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full && keep;

endmodule

`default_nettype wire

FILE: rtl/ox_queue.sv
// Short job queue between the front end and the execution engine.
`default_nettype none

module ox_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  ox_pkg::ox_job_t    push_job,
  input  wire                pop,
  output ox_pkg::ox_job_t    head,
  output ox_pkg::ox_qstat_t  qstat
);
  import ox_pkg::*;

  ox_job_t           q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_job;
  end

  assign head        = q_r[rd_ptr_r];
  assign qstat.full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign qstat.empty = (count_r == '0);

endmodule

`default_nettype wire

FILE: rtl/ox_back.sv
// Execution engine: parent stores, segment copy, filler scan and child emission.
`default_nettype none

module ox_back #(
  parameter int MAX_CITIES = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  input  ox_pkg::ox_qstat_t  qstat,
  input  ox_pkg::ox_job_t    head,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_stall,
  output ox_pkg::ox_out_t    out_data
);
  import ox_pkg::*;

  localparam int AW = $clog2(MAX_CITIES);

  ox_state_t state_r;
  ox_state_t state_nxt;

  logic [CITY_W-1:0] pa_mem    [MAX_CITIES];
  logic [CITY_W-1:0] pb_mem    [MAX_CITIES];
  logic [CITY_W-1:0] child_mem [MAX_CITIES];
  logic [CITY_W-1:0] pa_rdata_r;
  logic [CITY_W-1:0] pb_rdata_r;
  logic [CITY_W-1:0] child_rdata_r;
  logic              child_hit_r;

  logic [MAX_CITIES-1:0] child_vld_r;
  logic [CITY_SPACE-1:0] used_r;

  logic [AW-1:0] j_r;
  logic [AW-1:0] hi_r;
  logic [AW-1:0] last_r;
  logic [AW-1:0] rp_r;
  logic [AW-1:0] wp_r;
  logic [AW-1:0] k_r;
  logic [AW-1:0] e_r;
  logic [AW-1:0] remain_r;
  logic          swap_r;

  logic          stg_vld_r;
  logic          stg_fill_r;
  logic [AW-1:0] stg_pos_r;

  logic    out_valid_r;
  ox_out_t out_data_r;

  // run setup from the queue head
  logic [AW-1:0] job_lo;
  logic [AW-1:0] job_hi;
  logic [AW-1:0] job_last;
  logic [AW-1:0] job_start;
  logic [AW-1:0] job_remain;

  logic          start_run;
  logic          load_a_we;
  logic          load_b_we;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          emit_rd;
  logic          emit_ld;
  logic          can_load;

  logic [CITY_W-1:0] donor_data;
  logic [CITY_W-1:0] filler_data;
  logic [CITY_W-1:0] stg_data;
  logic              seg_wr;
  logic              fill_wr;
  logic              child_we;
  logic [AW-1:0]     child_waddr;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p,
                                             input logic [AW-1:0] top);
    wrap_inc = (p == top) ? '0 : p + AW'(1);
  endfunction

  assign job_lo     = head.lo[AW-1:0];
  assign job_hi     = head.hi[AW-1:0];
  assign job_last   = AW'(head.n - COUNT_W'(1));
  assign job_start  = wrap_inc(job_hi, job_last);
  assign job_remain = job_last - (job_hi - job_lo);

  assign can_load = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!qstat.empty && head.kind == KIND_RUN) state_nxt = ST_SEG;
      end
      ST_SEG: begin
        if (j_r == hi_r) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (k_r == last_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (can_load) state_nxt = (e_r == last_r) ? ST_IDLE : ST_EMIT_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    pop     = 1'b0;
    rd_en   = 1'b0;
    rd_addr = rp_r;
    emit_rd = 1'b0;
    emit_ld = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        pop = !qstat.empty;
      end
      ST_SEG: begin
        rd_en   = 1'b1;
        rd_addr = j_r;
      end
      ST_FILL: begin
        rd_en = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_EMIT_RD: begin
        emit_rd = 1'b1;
      end
      ST_EMIT_WR: begin
        emit_ld = can_load;
      end
      default: begin
      end
    endcase
  end

  assign start_run = pop && head.kind == KIND_RUN;
  assign load_a_we = pop && head.kind == KIND_LOAD_A;
  assign load_b_we = pop && head.kind == KIND_LOAD_B;

  // one read per cycle; the read data and its stage valid are registered together
  assign donor_data  = swap_r ? pb_rdata_r : pa_rdata_r;
  assign filler_data = swap_r ? pa_rdata_r : pb_rdata_r;
  assign stg_data    = stg_fill_r ? filler_data : donor_data;
  assign seg_wr      = stg_vld_r && !stg_fill_r;
  assign fill_wr     = stg_vld_r && stg_fill_r && remain_r != '0 && !used_r[stg_data];
  assign child_we    = seg_wr || fill_wr;
  assign child_waddr = fill_wr ? wp_r : stg_pos_r;

  always_ff @(posedge clk) begin
    if (load_a_we) pa_mem[head.position[AW-1:0]] <= head.city;
    if (rd_en)     pa_rdata_r <= pa_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (load_b_we) pb_mem[head.position[AW-1:0]] <= head.city;
    if (rd_en)     pb_rdata_r <= pb_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (child_we) child_mem[child_waddr] <= stg_data;
    if (emit_rd)  child_rdata_r <= child_mem[e_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stg_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      child_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      stg_vld_r <= rd_en;
      if (emit_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (start_run) begin
        used_r      <= '0;
        child_vld_r <= '0;
      end else if (child_we) begin
        used_r[stg_data]         <= 1'b1;
        child_vld_r[child_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    stg_fill_r <= (state_r == ST_FILL);
    stg_pos_r  <= j_r;
    if (start_run) begin
      j_r      <= job_lo;
      hi_r     <= job_hi;
      last_r   <= job_last;
      rp_r     <= job_start;
      wp_r     <= job_start;
      k_r      <= '0;
      e_r      <= '0;
      remain_r <= job_remain;
      swap_r   <= head.swap;
    end else begin
      if (state_r == ST_SEG) j_r <= j_r + AW'(1);
      if (state_r == ST_FILL) begin
        rp_r <= wrap_inc(rp_r, last_r);
        k_r  <= k_r + AW'(1);
      end
      if (fill_wr) begin
        wp_r     <= wrap_inc(wp_r, last_r);
        remain_r <= remain_r - AW'(1);
      end
      if (emit_ld) e_r <= e_r + AW'(1);
    end
    if (emit_rd) child_hit_r <= child_vld_r[e_r];
    if (emit_ld) begin
      out_data_r.child_position <= POS_W'(e_r);
      out_data_r.child_city     <= child_hit_r ? child_rdata_r : '0;
      out_data_r.last           <= (e_r == last_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_no_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !stg_vld_r)
    else $error("read stage busy while idle");

  a_seg_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
    seg_wr |=> used_r[$past(stg_data)])
    else $error("segment city not marked used");

  a_no_write_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_RD) |-> !child_we)
    else $error("child store written during emission");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_ld && e_r == last_r) |=> (state_r == ST_IDLE))
    else $error("run did not end after last position");

endmodule

`default_nettype wire

FILE: rtl/order_crossover.sv
// Top level of the order crossover (OX1) block.
//
//   port group  dir   handshake             carries
//   in_*        in    in_valid / in_stall   ox_in_t: command, position, city, cuts, swap
//   out_*       out   out_valid / out_stall ox_out_t: child_position, child_city, last
//   cfg_*       in    cfg_valid / cfg_ready city_count (7 bits)
//
// A load waits in the queue and is written to the parent store when the idle engine pops it.
// A run leaves the queue, copies the segment lo..hi, then scans the filler over n positions
// (n is city_count saturated to 2..MAX_CITIES), then reads and emits each result in turn.
// Synchronous active-low reset; the used-city map and child valid bits clear at run start.
// A two-entry queue keeps taking items while the engine runs; in_stall rises when it is full.
// out_stall holds the output register and stalls only the emission.
`default_nettype none

module order_crossover #(
  parameter int MAX_CITIES = 64
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  ox_pkg::ox_in_t            in_data,
  output logic                      out_valid,
  input  wire                       out_stall,
  output ox_pkg::ox_out_t           out_data,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [ox_pkg::COUNT_W-1:0] cfg_data
);
  import ox_pkg::*;

  ox_qstat_t qstat;
  ox_job_t   push_job;
  ox_job_t   head;
  logic      push;
  logic      pop;

  ox_front #(
    .MAX_CITIES(MAX_CITIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .job       (push_job)
  );

  ox_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  ox_back #(
    .MAX_CITIES(MAX_CITIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/order_crossover_tb.sv
// Self-checking testbench for the order crossover block, with a tour predictor and random stalls.
module order_crossover_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ox_pkg::*;

  localparam int TOUR_MAX = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int REST_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int BODY_ITEMS = 2;

  bit clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ox_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ox_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  // stimulus side: pending transactions and the parent contents they will leave
  ox_in_t item_backlog[$];
  logic [CITY_W-1:0] plan_a [TOUR_MAX];
  logic [CITY_W-1:0] plan_b [TOUR_MAX];

  // predictor side: parent stores and tour size as the block holds them
  logic [CITY_W-1:0] tour_a [TOUR_MAX];
  logic [CITY_W-1:0] tour_b [TOUR_MAX];
  logic [COUNT_W-1:0] count_shadow = COUNT_RESET;
  ox_out_t child_due[$];

  int idle_pct = 23;
  bit in_took;
  int err_count;
  int load_count;
  int run_count;
  int checked_count;
  int setting_count = 1;
  int cycle_count;

  order_crossover #(
    .MAX_CITIES(TOUR_MAX)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("order_crossover_tb: errors");
      $finish;
    end
  end

  // Build the child tour for one run transaction and queue its positions.
  task automatic predict_child(input ox_in_t it);
    int unsigned n, lo, hi, free_slots, placed, k, j;
    logic [CITY_W-1:0] child [TOUR_MAX];
    bit used [CITY_SPACE];
    logic [CITY_W-1:0] c;
    ox_out_t r;
    n = 32'(count_shadow);
    if (count_shadow < COUNT_MIN) n = 32'(COUNT_MIN);
    if (count_shadow > TOUR_MAX) n = TOUR_MAX;
    lo = 32'((it.cut_first < it.cut_second) ? it.cut_first : it.cut_second);
    hi = 32'((it.cut_first < it.cut_second) ? it.cut_second : it.cut_first);
    if (lo > n - 1) lo = n - 1;
    if (hi > n - 1) hi = n - 1;
    for (j = 0; j < TOUR_MAX; j++) begin
      child[j] = '0;
      used[j] = 1'b0;
    end
    for (j = lo; j <= hi; j++) begin
      c = it.swap_parents ? tour_b[j] : tour_a[j];
      child[j] = c;
      used[c] = 1'b1;
    end
    // scan the filler from just past the segment, wrapping, skipping cities already placed
    free_slots = n - (hi - lo + 1);
    placed = 0;
    for (k = 0; k < n && placed < free_slots; k++) begin
      c = it.swap_parents ? tour_a[(hi + 1 + k) % n] : tour_b[(hi + 1 + k) % n];
      if (!used[c]) begin
        child[(hi + 1 + placed) % n] = c;
        used[c] = 1'b1;
        placed++;
      end
    end
    for (j = 0; j < n; j++) begin
      r.child_position = POS_W'(j);
      r.child_city = child[j];
      r.last = (j == n - 1);
      child_due.push_back(r);
    end
    run_count++;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the stalled transaction
    end else if (item_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
      in_valid <= 1'b1;
      in_data <= item_backlog.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    ox_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (child_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, got pos %0d city %0d last %0d",
                   $time, out_data.child_position, out_data.child_city, out_data.last);
        end else begin
          want = child_due.pop_front();
          checked_count++;
          if (out_data.child_position !== want.child_position) begin
            err_count++;
            $display("%0t: child_position expected %0d got %0d", $time,
                     want.child_position, out_data.child_position);
          end
          if (out_data.child_city !== want.child_city) begin
            err_count++;
            $display("%0t: child_city at %0d expected %0d got %0d", $time,
                     want.child_position, want.child_city, out_data.child_city);
          end
          if (out_data.last !== want.last) begin
            err_count++;
            $display("%0t: last at %0d expected %0d got %0d", $time,
                     want.child_position, want.last, out_data.last);
          end
        end
      end
      in_took = in_valid && !in_stall;
      if (in_took) begin
        case (in_data.command)
          CMD_LOAD_A: begin
            tour_a[in_data.position] = in_data.city;
            load_count++;
          end
          CMD_LOAD_B: begin
            tour_b[in_data.position] = in_data.city;
            load_count++;
          end
          CMD_RUN: predict_child(in_data);
          default: ;
        endcase
      end
    end
  end

  function automatic ox_in_t rand_item(input logic [1:0] cmd);
    logic [$bits(ox_in_t)-1:0] raw;
    ox_in_t it;
    raw = $bits(ox_in_t)'($urandom);
    it = raw;
    it.command = cmd;
    return it;
  endfunction

  task automatic push_load(input logic [1:0] cmd, input int unsigned pos,
                           input int unsigned cty);
    ox_in_t it;
    it = rand_item(cmd);
    it.position = POS_W'(pos);
    it.city = CITY_W'(cty);
    if (cmd == CMD_LOAD_A) plan_a[it.position] = it.city;
    else plan_b[it.position] = it.city;
    item_backlog.push_back(it);
  endtask

  task automatic push_run(input int unsigned c1, input int unsigned c2, input bit sw);
    ox_in_t it;
    it = rand_item(CMD_RUN);
    it.cut_first = POS_W'(c1);
    it.cut_second = POS_W'(c2);
    it.swap_parents = sw;
    item_backlog.push_back(it);
  endtask

  // Write positions 0..m-1 of one parent with a shuffled tour of cities 0..m-1.
  task automatic load_permutation(input logic [1:0] cmd, input int unsigned m);
    int unsigned perm [TOUR_MAX];
    int unsigned i, k, t;
    for (i = 0; i < m; i++) perm[i] = i;
    for (i = m - 1; i > 0; i--) begin
      k = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[k];
      perm[k] = t;
    end
    for (i = 0; i < m; i++) push_load(cmd, i, perm[i]);
  endtask

  // Hold off until every transaction is in and every child position is out, then rest.
  task automatic drain_and_rest();
    @(posedge clk);
    while (item_backlog.size() != 0 || in_valid || child_due.size() != 0) @(posedge clk);
    repeat (REST_CYCLES) @(posedge clk);
  endtask

  task automatic set_city_count(input logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    count_shadow = value;
    setting_count++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [COUNT_W-1:0] value);
    int unsigned n, added, p, q, t, pick;
    logic [1:0] cmd;
    set_city_count(value);
    n = 32'(value);
    if (value < COUNT_MIN) n = 32'(COUNT_MIN);
    if (value > TOUR_MAX) n = TOUR_MAX;
    added = 0;
    while (added < BODY_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // exchange two cities within one parent, then cross
        cmd = $urandom_range(1) ? CMD_LOAD_B : CMD_LOAD_A;
        p = $urandom_range(n - 1);
        q = $urandom_range(n - 1);
        t = 32'((cmd == CMD_LOAD_A) ? plan_a[p] : plan_b[p]);
        push_load(cmd, p, 32'((cmd == CMD_LOAD_A) ? plan_a[q] : plan_b[q]));
        push_load(cmd, q, t);
        if ($urandom_range(1)) push_run($urandom_range(n - 1), $urandom_range(n - 1),
                                        1'($urandom_range(1)));
        else push_run($urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
        added += 3;
      end else if (pick < 75) begin
        push_run($urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
        added++;
      end else if (pick < 88) begin
        push_load($urandom_range(1) ? CMD_LOAD_B : CMD_LOAD_A, $urandom_range(63),
                  $urandom_range(63));
        added++;
      end else begin
        item_backlog.push_back(rand_item(CMD_UNUSED));
        added++;
      end
    end
    drain_and_rest();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full tours in both parents, then runs at the reset tour size, all without idling
    idle_pct = 0;
    load_permutation(CMD_LOAD_A, TOUR_MAX);
    load_permutation(CMD_LOAD_B, TOUR_MAX);
    push_run(0, 0, 1'b0);
    push_run(63, 63, 1'b1);
    push_run(40, 7, 1'b0);
    push_run(0, 63, 1'b1);
    item_backlog.push_back(rand_item(CMD_UNUSED));
    drain_and_rest();
    idle_pct = 23;

    set_city_count(COUNT_MIN);
    push_run(0, 1, 1'b0);
    push_run(0, 0, 1'b1);
    push_run(63, 5, 1'b0);
    drain_and_rest();

    set_city_count(COUNT_W'(TOUR_MAX));
    push_run(0, 63, 1'b0);
    push_run(32, 31, 1'b1);
    // duplicate a city in each parent so some child positions stay unfilled
    push_load(CMD_LOAD_A, 5, plan_a[6]);
    push_load(CMD_LOAD_B, 9, plan_b[10]);
    push_run(20, 40, 1'b0);
    push_run(5, 6, 1'b1);
    drain_and_rest();

    set_city_count('0);
    push_run(1, 0, 1'b1);
    drain_and_rest();
    set_city_count('1);
    push_run(17, 62, 1'b0);
    drain_and_rest();

    random_phase(7'd5);
    random_phase(7'd2);
    random_phase(7'd12);
    random_phase(7'd8);
    random_phase(7'd64);
    random_phase(7'd3);
    random_phase(COUNT_W'($urandom_range(16, 2)));
    random_phase(7'd1);

    $display("covered %0d parent loads and %0d crossover runs over %0d tour sizes",
             load_count, run_count, setting_count);
    $display("compared %0d child positions, %0d mismatches", checked_count, err_count);
    if (err_count == 0) begin
      $display("order_crossover_tb: clean");
    end else begin
      $display("order_crossover_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ox_pkg.sv
rtl/ox_front.sv
rtl/ox_queue.sv
rtl/ox_back.sv
rtl/order_crossover.sv
tb/order_crossover_tb.sv
